// ----- hdl/mbed_pkg.sv -----
package mbed_pkg;

  localparam int WINDOW     = 8;
  localparam int PTR_W      = $clog2(WINDOW);
  localparam int IN_W       = 16;
  localparam int ACC_W      = 2 * IN_W;
  localparam int RAD_W      = ACC_W + 8;
  localparam int MAG_W      = 20;
  localparam int REM_W      = MAG_W + 3;
  localparam int SUM_W      = MAG_W + PTR_W;
  localparam int DIFF_W     = SUM_W + 2;
  localparam int IDX_W      = 8;
  localparam int THR_W      = 20;
  localparam int SETTLE_W   = 8;
  localparam int MAXLEN_W   = 9;
  localparam int CFG_W      = 20;
  localparam int CFG_ADDR_W = 2;
  localparam int ROOT_STEPS = MAG_W;
  localparam int CNT_W      = $clog2(ROOT_STEPS);
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 32;
  localparam int REASON_W   = 2;

  localparam logic [THR_W-1:0]    THR_RESET    = THR_W'(48);
  localparam logic [SETTLE_W-1:0] SETTLE_RESET = SETTLE_W'(5);
  localparam logic [MAXLEN_W-1:0] MAXLEN_RESET = MAXLEN_W'(256);

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_NEAR_THRESHOLD = 2'd0,
    REG_SETTLE_COUNT   = 2'd1,
    REG_MAX_LENGTH     = 2'd2
  } reg_idx_t;

  typedef enum logic [REASON_W-1:0] {
    END_NONE    = 2'd0,
    END_SETTLED = 2'd1,
    END_MAXLEN  = 2'd2
  } reason_t;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ROOT_LD,
    ST_ROOT,
    ST_UPD,
    ST_EVAL
  } state_t;

  typedef struct packed {
    logic  cap;
    logic  mul_en;
    axis_t mul_sel;
    logic  root_ld;
    logic  root_en;
    logic  upd_en;
    logic  eval_en;
  } mbed_cmd_t;

  typedef struct packed {
    logic out_busy;
  } mbed_sts_t;

endpackage

// ----- hdl/motion_burst_end_detector.sv -----
// Each accepted input word is squared axis by axis on the shared squaring multiplier,
// rooted by the 20-step bit-serial square root, then used for window update and compare;
// an output stall holds the compare, and no new input word is taken until it completes.
// A new input word is taken while the previous result still waits on the output.
// Reset (rst, synchronous): registers return to 48 / 5 / 256, window and counters clear.
// Output register empties on reset.
module motion_burst_end_detector (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [mbed_pkg::IN_DATA_W-1:0]      s_tdata,   // accel_x, accel_y, accel_z
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [mbed_pkg::OUT_DATA_W-1:0]     m_tdata,   // magnitude, sample_index, zero pad
  output logic                                m_tlast,
  output logic [mbed_pkg::REASON_W-1:0]       m_tuser,   // end_reason
  input  logic                                cfg_we,
  input  logic [mbed_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [mbed_pkg::CFG_W-1:0]          cfg_wdata
);

  mbed_pkg::mbed_cmd_t cmd;
  mbed_pkg::mbed_sts_t sts;

  mbed_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mbed_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// ----- hdl/mbed_ctrl.sv -----
module mbed_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  mbed_pkg::mbed_sts_t sts,
  output mbed_pkg::mbed_cmd_t cmd
);

  mbed_pkg::state_t             state, state_next;
  logic [mbed_pkg::CNT_W-1:0]   cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mbed_pkg::ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    s_tready    = 1'b0;
    cmd         = '0;
    cmd.mul_sel = mbed_pkg::AXIS_X;
    unique case (state)
      mbed_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.cap    = 1'b1;
          cnt_next   = '0;
          state_next = mbed_pkg::ST_MUL;
        end
      end
      mbed_pkg::ST_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = mbed_pkg::axis_t'(cnt[1:0]);
        if (cnt[1:0] == mbed_pkg::AXIS_Z) begin
          cnt_next   = '0;
          state_next = mbed_pkg::ST_ROOT_LD;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      mbed_pkg::ST_ROOT_LD: begin
        cmd.root_ld = 1'b1;
        cnt_next    = '0;
        state_next  = mbed_pkg::ST_ROOT;
      end
      mbed_pkg::ST_ROOT: begin
        cmd.root_en = 1'b1;
        if (cnt == mbed_pkg::CNT_W'(mbed_pkg::ROOT_STEPS - 1)) begin
          cnt_next   = '0;
          state_next = mbed_pkg::ST_UPD;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      mbed_pkg::ST_UPD: begin
        cmd.upd_en = 1'b1;
        state_next = mbed_pkg::ST_EVAL;
      end
      mbed_pkg::ST_EVAL: begin
        if (!sts.out_busy) begin
          cmd.eval_en = 1'b1;
          state_next  = mbed_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mbed_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- hdl/mbed_dp.sv -----
module mbed_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [mbed_pkg::IN_DATA_W-1:0]      s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [mbed_pkg::OUT_DATA_W-1:0]     m_tdata,
  output logic                                m_tlast,
  output logic [mbed_pkg::REASON_W-1:0]       m_tuser,
  input  logic                                cfg_we,
  input  logic [mbed_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [mbed_pkg::CFG_W-1:0]          cfg_wdata,
  input  mbed_pkg::mbed_cmd_t                 cmd,
  output mbed_pkg::mbed_sts_t                 sts
);

  logic [mbed_pkg::THR_W-1:0]    near_threshold;
  logic [mbed_pkg::SETTLE_W-1:0] settle_count;
  logic [mbed_pkg::MAXLEN_W-1:0] max_length;

  logic signed [mbed_pkg::IN_W-1:0]  ax, ay, az, op;
  logic signed [mbed_pkg::ACC_W-1:0] prod;
  logic [mbed_pkg::ACC_W-1:0]        acc;

  logic [mbed_pkg::RAD_W-1:0] rad;
  logic [mbed_pkg::REM_W-1:0] rem, rem_sh, trial;
  logic [mbed_pkg::MAG_W-1:0] root;

  logic [mbed_pkg::MAG_W-1:0]    win [mbed_pkg::WINDOW];
  logic [mbed_pkg::PTR_W-1:0]    ptr;
  logic [mbed_pkg::SUM_W-1:0]    sum, sum_next;
  logic [mbed_pkg::SETTLE_W-1:0] near_run, near_run_next;
  logic [mbed_pkg::MAXLEN_W-1:0] samples, samples_next;

  logic signed [mbed_pkg::DIFF_W-1:0] diff;
  logic [mbed_pkg::DIFF_W-1:0]        diff_abs, thr_scaled;
  logic                               near, settled, maxed;
  mbed_pkg::reason_t                  reason;

  always_ff @(posedge clk) begin
    if (rst) begin
      near_threshold <= mbed_pkg::THR_RESET;
      settle_count   <= mbed_pkg::SETTLE_RESET;
      max_length     <= mbed_pkg::MAXLEN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        mbed_pkg::REG_NEAR_THRESHOLD: near_threshold <= cfg_wdata[mbed_pkg::THR_W-1:0];
        mbed_pkg::REG_SETTLE_COUNT:   settle_count   <= cfg_wdata[mbed_pkg::SETTLE_W-1:0];
        mbed_pkg::REG_MAX_LENGTH:     max_length     <= cfg_wdata[mbed_pkg::MAXLEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cmd.mul_sel)
      mbed_pkg::AXIS_X: op = ax;
      mbed_pkg::AXIS_Y: op = ay;
      mbed_pkg::AXIS_Z: op = az;
      default:          op = ax;
    endcase
    prod = op * op;
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      ax  <= s_tdata[15:0];
      ay  <= s_tdata[31:16];
      az  <= s_tdata[47:32];
      acc <= '0;
    end else if (cmd.mul_en) begin
      acc <= acc + $unsigned(prod);
    end
  end

  always_comb begin
    rem_sh = {rem[mbed_pkg::REM_W-3:0], rad[mbed_pkg::RAD_W-1 -: 2]};
    trial  = {1'b0, root, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (cmd.root_ld) begin
      rad  <= {acc, 8'h00};
      rem  <= '0;
      root <= '0;
    end else if (cmd.root_en) begin
      rad <= {rad[mbed_pkg::RAD_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem  <= rem_sh - trial;
        root <= {root[mbed_pkg::MAG_W-2:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[mbed_pkg::MAG_W-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    sum_next   = sum + mbed_pkg::SUM_W'(root) - mbed_pkg::SUM_W'(win[ptr]);
    diff       = $signed(mbed_pkg::DIFF_W'(root) * mbed_pkg::DIFF_W'(mbed_pkg::WINDOW))
               - $signed(mbed_pkg::DIFF_W'(sum));
    diff_abs   = diff[mbed_pkg::DIFF_W-1] ? mbed_pkg::DIFF_W'(-diff) : mbed_pkg::DIFF_W'(diff);
    thr_scaled = mbed_pkg::DIFF_W'(near_threshold) * mbed_pkg::DIFF_W'(mbed_pkg::WINDOW);
    near       = diff_abs < thr_scaled;
    if (!near) begin
      near_run_next = '0;
    end else if (near_run != '1) begin
      near_run_next = near_run + 1'b1;
    end else begin
      near_run_next = near_run;
    end
    samples_next = (samples != '1) ? samples + 1'b1 : samples;
    settled      = near_run_next >= settle_count;
    maxed        = samples_next >= max_length;
    if (settled) begin
      reason = mbed_pkg::END_SETTLED;
    end else if (maxed) begin
      reason = mbed_pkg::END_MAXLEN;
    end else begin
      reason = mbed_pkg::END_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < mbed_pkg::WINDOW; i++) begin
        win[i] <= '0;
      end
      ptr      <= '0;
      sum      <= '0;
      near_run <= '0;
      samples  <= '0;
    end else if (cmd.upd_en) begin
      win[ptr] <= root;
      sum      <= sum_next;
      ptr      <= (ptr == mbed_pkg::PTR_W'(mbed_pkg::WINDOW - 1)) ? '0 : ptr + 1'b1;
    end else if (cmd.eval_en) begin
      if (reason != mbed_pkg::END_NONE) begin
        for (int i = 0; i < mbed_pkg::WINDOW; i++) begin
          win[i] <= '0;
        end
        ptr      <= '0;
        sum      <= '0;
        near_run <= '0;
        samples  <= '0;
      end else begin
        near_run <= near_run_next;
        samples  <= samples_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.eval_en) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval_en) begin
      m_tdata <= {4'h0, samples[mbed_pkg::IDX_W-1:0], root};
      m_tlast <= (reason != mbed_pkg::END_NONE);
      m_tuser <= reason;
    end
  end

  assign sts.out_busy = m_tvalid && !m_tready;

endmodule

// ----- hdl/mbed_chk.sv -----
module mbed_chk (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [mbed_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic                            m_tlast,
  input logic [mbed_pkg::REASON_W-1:0]   m_tuser
);

  a_last_matches_reason: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (m_tuser != mbed_pkg::END_NONE)))
    else $error("tlast disagrees with end reason");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled output word changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken again while busy");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind motion_burst_end_detector mbed_chk u_mbed_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);
